// ----- rtl/bdq_pkg.sv -----
// Shared types and constants for the bounded deque with search.
package bdq_pkg;

    // Field widths of the request and response payloads.
    localparam int MODE_W  = 3;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    // Request operation codes.
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SEARCH     = 3'd4;

    // Request payload.
    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [VALUE_W-1:0] value;
    } bdq_req_t;

    // Response payload.
    typedef struct packed {
        logic               ok;
        logic [COUNT_W-1:0] count;
    } bdq_rsp_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } bdq_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic apply_op;
        logic search_start;
        logic search_step;
        logic search_end;
        logic rsp_load;
    } bdq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;
        logic hit;
        logic last;
    } bdq_status_t;

endpackage

// ----- rtl/bdq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/bdq_ctrl.sv -----
// Controller state machine for the bounded deque with search.
module bdq_ctrl
    import bdq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic [MODE_W-1:0]   req_mode,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    input  bdq_status_t         status,
    output bdq_cmd_t            cmd
);

    bdq_state_t state_reg;
    bdq_state_t state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;

    // State and response-valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (req_mode == MODE_SEARCH && !status.count_zero)
                    begin
                        cmd.search_start = 1'b1;
                        state_next       = ST_SEARCH;
                    end
                    else
                    begin
                        cmd.apply_op = 1'b1;
                        state_next   = ST_DONE;
                    end
                end
            end
            ST_SEARCH:
            begin
                cmd.search_step = 1'b1;
                if (status.hit || status.last)
                begin
                    cmd.search_end = 1'b1;
                    state_next     = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Move the result into the output register once it is free.
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.rsp_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The output register stays full until its transfer completes.
    assign rsp_valid_next = cmd.rsp_load | (rsp_valid_reg & ~rsp_ready);
    assign rsp_valid      = rsp_valid_reg;

`ifndef ASSERT_OFF
    // A result never overwrites one that has not been transferred.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rsp_load |-> (!rsp_valid_reg || rsp_ready))
        else $error("response loaded while output register is occupied");

    // A new response only appears after the done state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("response valid rose outside the done state");

    // An accepted request always leaves the idle state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg != ST_IDLE))
        else $error("accepted request did not start work");
`endif

endmodule

// ----- rtl/bdq_datapath.sv -----
// Datapath for the bounded deque: pointers, entry store, search compare and result registers.
module bdq_datapath
    import bdq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  bdq_req_t    req,
    input  bdq_cmd_t    cmd,
    output bdq_status_t status,
    output bdq_rsp_t    rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_X    = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_SLOT  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT  = CW'(DEPTH);

    logic [AW-1:0]         front_reg;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         k_reg;
    logic                  pend_reg;
    logic                  pend_last_reg;
    logic [DATA_WIDTH-1:0] key_reg;
    bdq_rsp_t              res_reg;
    bdq_rsp_t              rsp_reg;

    logic [VALUE_W-1:0]    value_bits;
    logic [DATA_WIDTH-1:0] value_data;
    logic [AW-1:0]         front_dec;
    logic [AW-1:0]         front_inc;
    logic [AW-1:0]         back_slot;
    logic                  full;
    logic                  empty;
    logic                  op_ok;
    logic [AW-1:0]         op_front;
    logic [CW-1:0]         op_count;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;
    logic                  issue;

    // Position base+ofs wrapped into the circular buffer.
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [AW-1:0] ofs);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, ofs};
        if (sum >= DEPTH_X)
        begin
            sum = sum - DEPTH_X;
        end
        return sum[AW-1:0];
    endfunction

    // The value is taken as raw bits and fitted to the stored width.
    assign value_bits = req.value;
    assign value_data = DATA_WIDTH'(value_bits);

    // Neighbor positions of the front entry and the slot past the back.
    assign front_dec = (front_reg == '0) ? LAST_SLOT : front_reg - AW'(1);
    assign front_inc = (front_reg == LAST_SLOT) ? '0 : front_reg + AW'(1);
    assign back_slot = slot_of(front_reg, count_reg[AW-1:0]);
    assign full      = (count_reg == DEPTH_CNT);
    assign empty     = (count_reg == '0);

    // Push and pop outcome for the request at the port.
    always_comb
    begin
        op_ok    = 1'b0;
        op_front = front_reg;
        op_count = count_reg;
        wr_en    = 1'b0;
        wr_addr  = back_slot;
        case (req.mode)
            MODE_PUSH_FRONT:
            begin
                if (!full)
                begin
                    op_ok    = 1'b1;
                    op_front = front_dec;
                    op_count = count_reg + CW'(1);
                    wr_en    = cmd.apply_op;
                    wr_addr  = front_dec;
                end
            end
            MODE_PUSH_BACK:
            begin
                if (!full)
                begin
                    op_ok    = 1'b1;
                    op_count = count_reg + CW'(1);
                    wr_en    = cmd.apply_op;
                end
            end
            MODE_POP_FRONT:
            begin
                if (!empty)
                begin
                    op_ok    = 1'b1;
                    op_front = front_inc;
                    op_count = count_reg - CW'(1);
                end
            end
            MODE_POP_BACK:
            begin
                if (!empty)
                begin
                    op_ok    = 1'b1;
                    op_count = count_reg - CW'(1);
                end
            end
            default:
            begin
                // Search on an empty store and unused codes change nothing.
            end
        endcase
    end

    // One read per search step, front to back.
    assign issue   = cmd.search_step && (k_reg < count_reg);
    assign rd_addr = slot_of(front_reg, k_reg[AW-1:0]);

    bdq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (value_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Pointer, count and search sequencing registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            k_reg         <= '0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
        end
        else
        begin
            if (cmd.apply_op)
            begin
                front_reg <= op_front;
                count_reg <= op_count;
            end
            if (cmd.search_start)
            begin
                k_reg         <= '0;
                pend_reg      <= 1'b0;
                pend_last_reg <= 1'b0;
            end
            else if (cmd.search_step)
            begin
                if (issue)
                begin
                    k_reg <= k_reg + CW'(1);
                end
                pend_reg      <= issue;
                pend_last_reg <= issue && ((k_reg + CW'(1)) == count_reg);
            end
            else
            begin
                pend_reg      <= 1'b0;
                pend_last_reg <= 1'b0;
            end
        end
    end

    // Search key, pending result and output payload.
    always_ff @(posedge clk)
    begin
        if (cmd.search_start)
        begin
            key_reg <= value_data;
        end
        if (cmd.apply_op)
        begin
            res_reg.ok    <= op_ok;
            res_reg.count <= COUNT_W'(op_count);
        end
        else if (cmd.search_end)
        begin
            res_reg.ok    <= status.hit;
            res_reg.count <= COUNT_W'(count_reg);
        end
        if (cmd.rsp_load)
        begin
            rsp_reg <= res_reg;
        end
    end

    // Compare the entry read in the previous cycle.
    assign status.count_zero = empty;
    assign status.hit        = pend_reg && (rd_data == key_reg);
    assign status.last       = pend_reg && pend_last_reg;
    assign rsp               = rsp_reg;

`ifndef ASSERT_OFF
    // The entry count never exceeds the buffer depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("entry count exceeds depth");

    // The last compare of a search covers exactly the held entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && pend_last_reg) |-> (k_reg == count_reg))
        else $error("search ended at the wrong entry");

    // A successful push or pop always changes the entry count.
    assert property (@(posedge clk) disable iff (!rst_n)
        ($past(rst_n) && $past(cmd.apply_op) && $past(op_ok))
            |-> (count_reg != $past(count_reg)))
        else $error("successful push or pop left the count unchanged");
`endif

endmodule

// ----- rtl/bounded_deque_with_search_core.sv -----
// Top level of the bounded deque with search: controller plus datapath.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  bdq_req_t  (mode, value)
//   rsp      out        rsp_valid / rsp_ready  bdq_rsp_t  (ok, count)
//
// Push, pop, unused modes and a search of an empty store pass from the idle state
// through the done state into the output register; a search reads the held entries
// front to back, since the single read port of the entry RAM feeds one compare a cycle.
// A new request is taken in the idle state even while the previous result waits.
// Reset clears the pointers and the count; the entry RAM is not cleared.
// A stalled response holds the next result in a staging register until it moves out.
module bounded_deque_with_search_core
    import bdq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  bdq_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output bdq_rsp_t rsp
);

    bdq_cmd_t    cmd;
    bdq_status_t status;

    // Sequencing of operations and the output handshake.
    bdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_mode  (req.mode),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Storage, pointers and search compare.
    bdq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cmd    (cmd),
        .status (status),
        .rsp    (rsp)
    );

endmodule

// ----- test/bounded_deque_with_search_core_tb.sv -----
// Self-checking testbench for the bounded deque with search core, driven by directed cases and random bursts.
`timescale 1ns / 100ps

module bounded_deque_with_search_core_tb;
    import bdq_pkg::*;

    localparam int          CLK_PERIOD       = 12;
    localparam int          RESET_CYCLES     = 12;
    localparam int          SLOTS            = 16;
    localparam int unsigned CYCLE_LIMIT      = 600000;
    localparam int unsigned LONG_HOLD_CYCLES = 400;
    localparam int unsigned TAIL_CYCLES      = 40;
    localparam int unsigned PHASE_ITEMS      = 500;
    localparam int unsigned MAX_REPORTS      = 10;

    // Mode codes that the block has no operation for.
    localparam logic [MODE_W-1:0] MODE_RESERVED_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RESERVED_HI = 3'd7;

    // Tracks the deque contents and the responses still owed by the block.
    class deque_scoreboard;
        logic [VALUE_W-1:0] slots [SLOTS];
        int unsigned        head;
        int unsigned        held;
        bdq_rsp_t           awaited [$];
        int unsigned        mismatches;

        function new();
            head       = 0;
            held       = 0;
            mismatches = 0;
        endfunction

        // Applies one accepted request to the shadow deque and queues its response.
        function void note_request(bdq_req_t r);
            bdq_rsp_t    want;
            int unsigned k;
            want.ok = 1'b0;
            case (r.mode)
                MODE_PUSH_FRONT:
                    if (held < SLOTS)
                    begin
                        head        = (head + SLOTS - 1) % SLOTS;
                        slots[head] = r.value;
                        held++;
                        want.ok = 1'b1;
                    end
                MODE_PUSH_BACK:
                    if (held < SLOTS)
                    begin
                        slots[(head + held) % SLOTS] = r.value;
                        held++;
                        want.ok = 1'b1;
                    end
                MODE_POP_FRONT:
                    if (held > 0)
                    begin
                        head = (head + 1) % SLOTS;
                        held--;
                        want.ok = 1'b1;
                    end
                MODE_POP_BACK:
                    if (held > 0)
                    begin
                        held--;
                        want.ok = 1'b1;
                    end
                MODE_SEARCH:
                    for (k = 0; k < held; k++)
                    begin
                        if (slots[(head + k) % SLOTS] == r.value)
                            want.ok = 1'b1;
                    end
                default:
                    want.ok = 1'b0;
            endcase
            want.count = COUNT_W'(held);
            awaited.push_back(want);
        endfunction

        // Compares one response transfer with the oldest owed response.
        function void check_response(bdq_rsp_t got);
            bdq_rsp_t want;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: response with none owed: ok=%0b count=%0d",
                             got.ok, got.count);
            end
            else
            begin
                want = awaited.pop_front();
                if (got.ok !== want.ok || got.count !== want.count)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("ERROR: response ok=%0b count=%0d, wanted ok=%0b count=%0d",
                                 got.ok, got.count, want.ok, want.count);
                end
            end
        endfunction

        function logic [VALUE_W-1:0] held_value(int unsigned k);
            return slots[(head + k) % SLOTS];
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction
    endclass

    logic     clk = 1'b0;
    logic     rst_n;
    logic     req_valid;
    logic     req_ready;
    bdq_req_t req;
    logic     rsp_valid;
    logic     rsp_ready;
    bdq_rsp_t rsp;

    deque_scoreboard board;
    int unsigned     src_idle_pct  = 0;
    int unsigned     sink_idle_pct = 0;
    int unsigned     hold_requests = 0;
    int unsigned     cycle_count   = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    bounded_deque_with_search_core #(
        .DEPTH      (SLOTS),
        .DATA_WIDTH (VALUE_W)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Response side: checks each transfer, then picks ready for the next cycle.
    initial
    begin : rsp_sink
        int unsigned hold_left;
        int unsigned holds_taken;
        hold_left   = 0;
        holds_taken = 0;
        rsp_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid === 1'b1 && rsp_ready === 1'b1)
                board.check_response(rsp);
            if (holds_taken != hold_requests)
            begin
                holds_taken = hold_requests;
                hold_left   = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Offers one request, with a random gap first, and waits for its transfer.
    task automatic send_req(input bdq_req_t r);
        if ($urandom_range(99) < src_idle_pct)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (req_ready !== 1'b1);
        board.note_request(r);
    endtask

    // Stops offering requests until every owed response has arrived.
    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    function automatic bdq_req_t make_req(input logic [MODE_W-1:0] m,
                                          input logic [VALUE_W-1:0] v);
        bdq_req_t r;
        r.mode  = m;
        r.value = v;
        return r;
    endfunction

    // Value mix: field extremes, small values that repeat, and full random words.
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(9))
            0:       v = {1'b1, {(VALUE_W - 1){1'b0}}};
            1:       v = {1'b0, {(VALUE_W - 1){1'b1}}};
            2:       v = '0;
            3:       v = '1;
            4:       v = VALUE_W'($urandom_range(15));
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic bdq_req_t push_req();
        return make_req($urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT, pick_value());
    endfunction

    function automatic bdq_req_t pop_req();
        return make_req($urandom_range(1) ? MODE_POP_BACK : MODE_POP_FRONT, $urandom);
    endfunction

    // Searches mostly for a value that is held, so that hits at every position occur.
    function automatic bdq_req_t search_req();
        if (board.held > 0 && $urandom_range(99) < 60)
            return make_req(MODE_SEARCH, board.held_value($urandom_range(board.held - 1)));
        return make_req(MODE_SEARCH, pick_value());
    endfunction

    function automatic bdq_req_t reserved_req();
        return make_req(MODE_W'($urandom_range(MODE_RESERVED_LO, MODE_RESERVED_HI)), $urandom);
    endfunction

    // Edge cases on an empty store, both extremes of the value, and emptying by either end.
    task automatic run_directed();
        logic [MODE_W-1:0] m;
        send_req(make_req(MODE_POP_FRONT, '0));
        send_req(make_req(MODE_POP_BACK, '1));
        send_req(make_req(MODE_SEARCH, '0));
        for (m = MODE_RESERVED_LO; m != MODE_RESERVED_HI; m++)
            send_req(make_req(m, $urandom));
        send_req(make_req(MODE_RESERVED_HI, $urandom));
        send_req(make_req(MODE_PUSH_FRONT, {1'b1, {(VALUE_W - 1){1'b0}}}));
        send_req(make_req(MODE_PUSH_BACK, {1'b0, {(VALUE_W - 1){1'b1}}}));
        send_req(make_req(MODE_PUSH_FRONT, '0));
        send_req(make_req(MODE_SEARCH, {1'b0, {(VALUE_W - 1){1'b1}}}));
        send_req(make_req(MODE_SEARCH, {1'b1, {(VALUE_W - 1){1'b0}}}));
        send_req(make_req(MODE_SEARCH, VALUE_W'(1)));
        send_req(make_req(MODE_RESERVED_LO, '0));
        send_req(make_req(MODE_POP_BACK, '0));
        send_req(make_req(MODE_POP_FRONT, '0));
        send_req(make_req(MODE_POP_FRONT, '0));
        send_req(make_req(MODE_PUSH_BACK, '1));
        send_req(make_req(MODE_POP_BACK, '0));
        send_req(make_req(MODE_SEARCH, '1));
    endtask

    // Random bursts: fill to full and beyond, drain to empty and beyond, noise and mixes.
    task automatic run_random(input int unsigned n_items);
        int unsigned done_items;
        int unsigned pick;
        int unsigned burst;
        int unsigned i;
        done_items = 0;
        while (done_items < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 25)
            begin
                while (board.held < SLOTS)
                begin
                    send_req(($urandom_range(3) == 0) ? search_req() : push_req());
                    done_items++;
                end
                burst = $urandom_range(1, 3);
                for (i = 0; i < burst; i++)
                    send_req(($urandom_range(2) == 0) ? search_req() : push_req());
                done_items += burst;
            end
            else if (pick < 45)
            begin
                while (board.held > 0)
                begin
                    send_req(($urandom_range(3) == 0) ? search_req() : pop_req());
                    done_items++;
                end
                burst = $urandom_range(1, 3);
                for (i = 0; i < burst; i++)
                    send_req(($urandom_range(2) == 0) ? search_req() : pop_req());
                done_items += burst;
            end
            else if (pick < 50)
            begin
                // Undefined modes only; they change nothing and are not counted.
                burst = $urandom_range(1, 3);
                for (i = 0; i < burst; i++)
                    send_req(reserved_req());
            end
            else
            begin
                burst = $urandom_range(4, 16);
                for (i = 0; i < burst; i++)
                begin
                    pick = $urandom_range(99);
                    if (pick < 35)
                        send_req(push_req());
                    else if (pick < 65)
                        send_req(pop_req());
                    else
                        send_req(search_req());
                end
                done_items += burst;
            end
        end
    endtask

    // Main sequence: reset, then three idle profiles, then the verdict.
    initial
    begin
        board = new();
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct  = 13;
        sink_idle_pct = 55;
        run_directed();
        hold_requests++;
        run_random(PHASE_ITEMS);
        wait_drained();

        src_idle_pct  = 55;
        sink_idle_pct = 13;
        run_random(PHASE_ITEMS / 2);
        hold_requests++;
        run_random(PHASE_ITEMS / 2);
        wait_drained();

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_random(PHASE_ITEMS);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (board.mismatches == 0 && board.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
